### hdl/crast_pkg.sv
// ============================================================================
// crast_pkg
// Shared types and constants of the circle rasteriser.
// ============================================================================
package crast_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int QUEUE_DEPTH    = 2;
    localparam int FIELD_BITS     = 16;
    localparam int RADIUS_BITS    = 15;
    localparam int OFFS_BITS      = 16;
    localparam int DEC_BITS       = 20;
    localparam int SLOTS          = 8;
    localparam int SLOT_BITS      = $clog2(SLOTS);

    localparam logic REQ_START = 1'b0;
    localparam logic REQ_STEP  = 1'b1;

    localparam logic [DEC_BITS-1:0] D_INIT      = DEC_BITS'(3);
    localparam logic [DEC_BITS-1:0] D_STEP_DIAG = DEC_BITS'(10);
    localparam logic [DEC_BITS-1:0] D_STEP_AXIS = DEC_BITS'(6);

    localparam logic [SLOTS-1:0] MASK_OUTLINE  = '1;
    localparam logic [SLOTS-1:0] MASK_FINISHED = SLOTS'(1);

    typedef struct packed {
        logic             fin;
        logic             fill;
        logic [SLOTS-1:0] mask;
    } t_grp_ctl;

    localparam int GRP_CTL_BITS = $bits(t_grp_ctl);

endpackage

### hdl/circle_rasterizer.sv
// ============================================================================
// circle_rasterizer
// Midpoint circle rasteriser: start and step items in, pixel spans out.
// ============================================================================
//  channel  | handshake   | fields
//  ---------+-------------+------------------------------------------------------------
//  request  | push / full | req_type, center_x, center_y, radius, pen_color, fill_mode
//  span     | empty / pop | span_x_start, span_x_end, span_y, span_color, finished, last
//
//  An item is taken while the two-entry group queue has room. With the back end idle
//  it passes the queue and the back end's command registers before its first span is
//  registered. Spans leave the single result register at one per cycle while it is
//  empty or popped: 8 spans per item in outline mode, 4 in fill mode (2 on the step
//  after a zero-radius start), 1 for finished. Reset is synchronous; it empties the
//  queue and the result register and clears the active flag. pop low holds the
//  result; full rises when two groups wait behind the one being expanded.
// ============================================================================
module circle_rasterizer
    import crast_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   push,
    output logic                   full,
    input  logic                   i_req_type,
    input  logic [FIELD_BITS-1:0]  i_center_x,
    input  logic [FIELD_BITS-1:0]  i_center_y,
    input  logic [RADIUS_BITS-1:0] i_radius,
    input  logic [FIELD_BITS-1:0]  i_pen_color,
    input  logic                   i_fill_mode,
    output logic                   empty,
    input  logic                   pop,
    output logic [FIELD_BITS-1:0]  o_span_x_start,
    output logic [FIELD_BITS-1:0]  o_span_x_end,
    output logic [FIELD_BITS-1:0]  o_span_y,
    output logic [FIELD_BITS-1:0]  o_span_color,
    output logic                   o_finished,
    output logic                   o_last
);

    localparam int CMD_BITS = GRP_CTL_BITS + 4 * COORD_BITS + FIELD_BITS;

    t_grp_ctl              f_ctl, b_ctl;
    logic [COORD_BITS-1:0] f_cc, f_cr, f_dx, f_dy;
    logic [COORD_BITS-1:0] b_cc, b_cr, b_dx, b_dy;
    logic [FIELD_BITS-1:0] f_color, b_color;
    logic [CMD_BITS-1:0]   q_wdata, q_rdata;
    logic                  accept, q_valid, q_take;

    assign accept  = push && !full;
    assign q_wdata = {f_ctl, f_cc, f_cr, f_color, f_dx, f_dy};
    assign {b_ctl, b_cc, b_cr, b_color, b_dx, b_dy} = q_rdata;

    crast_front #(.COORD_BITS(COORD_BITS)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (accept),
        .i_req_type  (i_req_type),
        .i_center_x  (i_center_x),
        .i_center_y  (i_center_y),
        .i_radius    (i_radius),
        .i_pen_color (i_pen_color),
        .i_fill_mode (i_fill_mode),
        .o_ctl       (f_ctl),
        .o_cc        (f_cc),
        .o_cr        (f_cr),
        .o_color     (f_color),
        .o_dx        (f_dx),
        .o_dy        (f_dy)
    );

    crast_fifo #(.WIDTH(CMD_BITS), .DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (accept),
        .i_wdata (q_wdata),
        .o_full  (full),
        .i_rd    (q_take),
        .o_rdata (q_rdata),
        .o_valid (q_valid)
    );

    crast_back #(.COORD_BITS(COORD_BITS)) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd_valid    (q_valid),
        .o_cmd_take     (q_take),
        .i_ctl          (b_ctl),
        .i_cc           (b_cc),
        .i_cr           (b_cr),
        .i_color        (b_color),
        .i_dx           (b_dx),
        .i_dy           (b_dy),
        .o_empty        (empty),
        .i_pop          (pop),
        .o_span_x_start (o_span_x_start),
        .o_span_x_end   (o_span_x_end),
        .o_span_y       (o_span_y),
        .o_span_color   (o_span_color),
        .o_finished     (o_finished),
        .o_last         (o_last)
    );

endmodule

### hdl/crast_fifo.sv
// ============================================================================
// crast_fifo
// Small register queue between the front and back ends.
// ============================================================================
module crast_fifo
    import crast_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_full,
    input  logic             i_rd,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_valid
);

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]    r_mem [DEPTH];
    logic [PTR_BITS-1:0] r_wp, n_wp;
    logic [PTR_BITS-1:0] r_rp, n_rp;
    logic [CNT_BITS-1:0] r_cnt, n_cnt;
    logic                do_wr, do_rd;

    assign o_full  = (r_cnt == CNT_BITS'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_rdata = r_mem[r_rp];
    assign do_wr   = i_wr && !o_full;
    assign do_rd   = i_rd && o_valid;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (do_wr) begin
            n_wp = (r_wp == PTR_BITS'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (do_rd) begin
            n_rp = (r_rp == PTR_BITS'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (do_wr && !do_rd) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_rd && !do_wr) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

endmodule

### hdl/crast_front.sv
// ============================================================================
// crast_front
// Takes start and step items, keeps the circle state and issues one group
// command per item.
// ============================================================================
module crast_front
    import crast_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  logic                   i_req_type,
    input  logic [FIELD_BITS-1:0]  i_center_x,
    input  logic [FIELD_BITS-1:0]  i_center_y,
    input  logic [RADIUS_BITS-1:0] i_radius,
    input  logic [FIELD_BITS-1:0]  i_pen_color,
    input  logic                   i_fill_mode,
    output t_grp_ctl               o_ctl,
    output logic [COORD_BITS-1:0]  o_cc,
    output logic [COORD_BITS-1:0]  o_cr,
    output logic [FIELD_BITS-1:0]  o_color,
    output logic [COORD_BITS-1:0]  o_dx,
    output logic [COORD_BITS-1:0]  o_dy
);

    logic                        r_active;
    logic                        r_fill;
    logic [COORD_BITS-1:0]       r_cc;
    logic [COORD_BITS-1:0]       r_cr;
    logic [FIELD_BITS-1:0]       r_color;
    logic signed [OFFS_BITS-1:0] r_x, n_x;
    logic signed [OFFS_BITS-1:0] r_y, n_y;
    logic signed [DEC_BITS-1:0]  r_dec, n_dec;
    logic signed [DEC_BITS-1:0]  x_w, y_w;
    logic                        is_start, done;

    assign is_start = (i_req_type == REQ_START);
    assign done     = !r_active || (r_y < r_x);

    always_comb begin
        n_x = r_x + 1'b1;
        n_y = r_y;
        x_w = {{(DEC_BITS - OFFS_BITS){n_x[OFFS_BITS-1]}}, n_x};
        y_w = {{(DEC_BITS - OFFS_BITS){r_y[OFFS_BITS-1]}}, r_y};
        if (r_dec > 0) begin
            n_y   = r_y - 1'b1;
            y_w   = y_w - 1'b1;
            n_dec = r_dec + ((x_w - y_w) <<< 2) + D_STEP_DIAG;
        end else begin
            n_dec = r_dec + (x_w <<< 2) + D_STEP_AXIS;
        end
        if (is_start) begin
            n_x   = '0;
            n_y   = OFFS_BITS'(i_radius);
            n_dec = D_INIT - {{(DEC_BITS - RADIUS_BITS - 1){1'b0}}, i_radius, 1'b0};
        end
    end

    always_comb begin
        o_ctl.fin  = !is_start && done;
        o_ctl.fill = is_start ? i_fill_mode : r_fill;
        o_ctl.mask = MASK_OUTLINE;
        if (o_ctl.fin) begin
            o_ctl.mask = MASK_FINISHED;
        end else if (o_ctl.fill) begin
            o_ctl.mask = {4'b0000, !n_y[OFFS_BITS-1], !n_y[OFFS_BITS-1],
                          !n_x[OFFS_BITS-1], !n_x[OFFS_BITS-1]};
        end
        o_cc    = is_start ? i_center_x[COORD_BITS-1:0] : r_cc;
        o_cr    = is_start ? i_center_y[COORD_BITS-1:0] : r_cr;
        o_color = is_start ? i_pen_color : r_color;
        o_dx    = n_x[COORD_BITS-1:0];
        o_dy    = n_y[COORD_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else if (i_valid) begin
            r_active <= is_start || !done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && is_start) begin
            r_fill  <= i_fill_mode;
            r_cc    <= i_center_x[COORD_BITS-1:0];
            r_cr    <= i_center_y[COORD_BITS-1:0];
            r_color <= i_pen_color;
        end
        if (i_valid && (is_start || !done)) begin
            r_x   <= n_x;
            r_y   <= n_y;
            r_dec <= n_dec;
        end
    end

endmodule

### hdl/crast_back.sv
// ============================================================================
// crast_back
// Expands one group command into its spans in the result register, one per
// cycle while that register is empty or popped.
// ============================================================================
module crast_back
    import crast_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cmd_valid,
    output logic                  o_cmd_take,
    input  t_grp_ctl              i_ctl,
    input  logic [COORD_BITS-1:0] i_cc,
    input  logic [COORD_BITS-1:0] i_cr,
    input  logic [FIELD_BITS-1:0] i_color,
    input  logic [COORD_BITS-1:0] i_dx,
    input  logic [COORD_BITS-1:0] i_dy,
    output logic                  o_empty,
    input  logic                  i_pop,
    output logic [FIELD_BITS-1:0] o_span_x_start,
    output logic [FIELD_BITS-1:0] o_span_x_end,
    output logic [FIELD_BITS-1:0] o_span_y,
    output logic [FIELD_BITS-1:0] o_span_color,
    output logic                  o_finished,
    output logic                  o_last
);

    logic [SLOTS-1:0]      r_mask;
    logic                  r_fin, r_fill;
    logic [COORD_BITS-1:0] r_cc, r_cr, r_dx, r_dy;
    logic [FIELD_BITS-1:0] r_color;
    logic                  r_out_valid;

    logic [SLOTS-1:0]      pick, mask_after;
    logic [SLOT_BITS-1:0]  idx;
    logic                  advance, emit;
    logic [COORD_BITS-1:0] u, v, xs, xe, yy;

    assign advance    = !r_out_valid || i_pop;
    assign emit       = advance && (r_mask != '0);
    assign pick       = r_mask & (~r_mask + 1'b1);
    assign mask_after = r_mask & ~pick;
    assign o_cmd_take = i_cmd_valid && ((r_mask == '0) || (emit && (mask_after == '0)));
    assign o_empty    = !r_out_valid;

    always_comb begin
        idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (r_mask[i]) begin
                idx = SLOT_BITS'(i);
            end
        end
    end

    // fill: slot bit 1 swaps axes, bit 0 mirrors the row
    // outline: bit 2 swaps axes, bit 0 mirrors the column, bit 1 the row
    always_comb begin
        if (r_fill) begin
            u  = idx[1] ? r_dy : r_dx;
            v  = idx[1] ? r_dx : r_dy;
            xs = r_cc - u;
            xe = r_cc + u;
            yy = idx[0] ? r_cr - v : r_cr + v;
        end else begin
            u  = idx[2] ? r_dy : r_dx;
            v  = idx[2] ? r_dx : r_dy;
            xs = idx[0] ? r_cc - u : r_cc + u;
            xe = xs;
            yy = idx[1] ? r_cr - v : r_cr + v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd_take) begin
                r_mask <= i_ctl.mask;
            end else if (emit) begin
                r_mask <= mask_after;
            end
            if (advance) begin
                r_out_valid <= emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_take) begin
            r_fin   <= i_ctl.fin;
            r_fill  <= i_ctl.fill;
            r_cc    <= i_cc;
            r_cr    <= i_cr;
            r_color <= i_color;
            r_dx    <= i_dx;
            r_dy    <= i_dy;
        end
        if (emit) begin
            o_finished     <= r_fin;
            o_last         <= (mask_after == '0);
            o_span_x_start <= r_fin ? '0 : FIELD_BITS'(xs);
            o_span_x_end   <= r_fin ? '0 : FIELD_BITS'(xe);
            o_span_y       <= r_fin ? '0 : FIELD_BITS'(yy);
            o_span_color   <= r_fin ? '0 : r_color;
        end
    end

endmodule

### hdl/crast_checker.sv
// ============================================================================
// crast_checker
// Port-level checks of the circle rasteriser, bound to the top level.
// ============================================================================
module crast_checker
    import crast_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  full,
    input logic                  empty,
    input logic                  pop,
    input logic [FIELD_BITS-1:0] o_span_x_start,
    input logic [FIELD_BITS-1:0] o_span_x_end,
    input logic [FIELD_BITS-1:0] o_span_y,
    input logic [FIELD_BITS-1:0] o_span_color,
    input logic                  o_finished,
    input logic                  o_last
);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full)
        else $error("queues not empty after reset");

    a_fin_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_finished |-> o_last)
        else $error("finished item without last");

    a_fin_blank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_finished |-> (o_span_x_start == '0) && (o_span_x_end == '0)
                                 && (o_span_y == '0) && (o_span_color == '0))
        else $error("finished item carries a span");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_span_x_start) && $stable(o_span_x_end)
                           && $stable(o_span_y) && $stable(o_last))
        else $error("stalled result changed");

endmodule

bind circle_rasterizer crast_checker u_crast_checker (.*);
